[rtl/olir_pkg.sv]
package olir_pkg;

  // Fixed field widths of the request and response words.
  localparam int REQ_W    = 3;
  localparam int POS_W    = 4;
  localparam int DATA_W   = 32;
  localparam int ENTRY_W  = 5;
  localparam int STATUS_W = 2;

  // Default list capacity.
  localparam int DEF_CAPACITY = 16;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Action that one cell takes at the next clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOW,
    CELL_FROM_HIGH,
    CELL_CLEAR
  } cell_op_t;

endpackage

[rtl/olir_ifs.sv]
interface olir_req_if;
  import olir_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, req_type, position, data_in, input ready);
  modport sink (input valid, req_type, position, data_in, output ready);
endinterface

interface olir_rsp_if;
  import olir_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [ENTRY_W-1:0]       entry_count;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, read_value, entry_count, status, input ready);
  modport sink (input valid, read_value, entry_count, status, output ready);
endinterface

[rtl/olir_cell.sv]
module olir_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  olir_pkg::cell_op_t                op,
  input  logic signed [olir_pkg::DATA_W-1:0] load_data,
  input  logic signed [olir_pkg::DATA_W-1:0] low_data,
  input  logic signed [olir_pkg::DATA_W-1:0] high_data,
  output logic signed [olir_pkg::DATA_W-1:0] value
);
  import olir_pkg::*;

  // One list slot: hold, load new data, take a neighbor's entry, or clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      unique case (op)
        CELL_LOAD:      value <= load_data;
        CELL_FROM_LOW:  value <= low_data;
        CELL_FROM_HIGH: value <= high_data;
        CELL_CLEAR:     value <= '0;
        default:        value <= value;
      endcase
    end
  end

endmodule

[rtl/olir_ctrl.sv]
module olir_ctrl #(
  parameter int CAPACITY = olir_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                          fire,
  input  logic [olir_pkg::REQ_W-1:0]    req_type,
  input  logic [olir_pkg::POS_W-1:0]    position,
  input  logic [CNT_W-1:0]              count,
  output olir_pkg::cell_op_t            cell_ops [CAPACITY],
  output logic [CNT_W-1:0]              count_next,
  output logic [olir_pkg::STATUS_W-1:0] status
);
  import olir_pkg::*;

  // Compare width covers both the position field and the count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             is_full;
  logic             is_empty;
  logic             app_ok;
  logic             pop_ok;
  logic             ins_ok;
  logic             rem_ok;

  assign pos_c    = CMP_W'(position);
  assign cnt_c    = CMP_W'(count);
  assign is_full  = (cnt_c == CMP_W'(CAPACITY));
  assign is_empty = (count == '0);

  // Decode the request against the current fill level.
  always_comb begin
    status     = ST_OK;
    app_ok     = 1'b0;
    pop_ok     = 1'b0;
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    count_next = count;
    unique case (req_type)
      REQ_APPEND: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          app_ok     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          pop_ok     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (is_full) begin
          status = ST_FULL;
        end else if (pos_c > cnt_c) begin
          status = ST_RANGE;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end else begin
          rem_ok     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (pos_c >= cnt_c) begin
          status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // Per-cell action. Slots past the end always hold zero, so a remove
  // pulls zero into the last valid slot from its upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_op
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

    always_comb begin
      cell_ops[i] = CELL_HOLD;
      if (fire) begin
        priority if (app_ok && IDX == cnt_c) begin
          cell_ops[i] = CELL_LOAD;
        end else if (pop_ok && IDX == cnt_c - CMP_W'(1)) begin
          cell_ops[i] = CELL_CLEAR;
        end else if (ins_ok && IDX == pos_c) begin
          cell_ops[i] = CELL_LOAD;
        end else if (ins_ok && IDX > pos_c && IDX <= cnt_c) begin
          cell_ops[i] = CELL_FROM_LOW;
        end else if (rem_ok && IDX >= pos_c && IDX < cnt_c) begin
          cell_ops[i] = CELL_FROM_HIGH;
        end else begin
          cell_ops[i] = CELL_HOLD;
        end
      end
    end
  end

endmodule

[rtl/ordered_list_insert_remove_unit.sv]
// A response word is valid in the cycle after its request word is taken.
// Throughput: one request per cycle; every cell of the chain updates at the
// same edge from one broadcast command, so no request waits on another.
// A response word that is not taken holds off the request side until it drains.
// Reset (synchronous, active high) clears every entry to zero, the count to
// zero and the response valid flag.
module ordered_list_insert_remove_unit #(
  parameter int CAPACITY = olir_pkg::DEF_CAPACITY
) (
  input logic       clk,
  input logic       rst,
  olir_req_if.sink   req,
  olir_rsp_if.source rsp
);
  import olir_pkg::*;

  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int READ_SPAN = 2 ** POS_W;

  logic                     fire;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [STATUS_W-1:0]      status_next;
  cell_op_t                 cell_ops [CAPACITY];
  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] read_span [READ_SPAN];
  logic signed [DATA_W-1:0] read_next;

  // A new word is taken whenever the response slot is free or draining.
  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  olir_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .fire       (fire),
    .req_type   (req.req_type),
    .position   (req.position),
    .count      (count),
    .cell_ops   (cell_ops),
    .count_next (count_next),
    .status     (status_next)
  );

  // Chain of cells; the ends see zero as their missing neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] low_in;
    logic signed [DATA_W-1:0] high_in;
    logic signed [DATA_W-1:0] value_out;

    if (i == 0) begin : g_first
      assign low_in = '0;
    end else begin : g_mid_low
      assign low_in = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign high_in = '0;
    end else begin : g_mid_high
      assign high_in = cell_val[i+1];
    end

    olir_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (cell_ops[i]),
      .load_data (req.data_in),
      .low_data  (low_in),
      .high_data (high_in),
      .value     (value_out)
    );

    assign cell_val[i] = value_out;
  end

  // Only the slots the position field can reach feed the read mux.
  for (genvar j = 0; j < READ_SPAN; j++) begin : g_span
    if (j < CAPACITY) begin : g_live
      assign read_span[j] = cell_val[j];
    end else begin : g_none
      assign read_span[j] = '0;
    end
  end

  assign read_next = (req.req_type == REQ_READ && status_next == ST_OK)
                     ? read_span[req.position] : '0;

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.read_value  <= read_next;
      rsp.entry_count <= ENTRY_W'(count_next);
      rsp.status      <= status_next;
    end
  end

endmodule
